/* hw/rtl/dmht_pkg.sv */
// ----------------------------------------------------------------------------
// dmht_pkg
// Types and constants shared by the direct-mapped hash table core and its
// slot divider and entry store.
// ----------------------------------------------------------------------------
package dmht_pkg;

	localparam int KEY_W   = 64;
	localparam int CAP_W   = 17;
	localparam int CNT_W   = $clog2(KEY_W);
	localparam int SCORE_W = 16;
	localparam int DEPTH_W = 8;
	localparam int BOUND_W = 2;
	localparam int MOVE_W  = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 17'd65521;

	typedef enum logic [1:0] {
		ACT_PROBE = 2'd0,
		ACT_STORE = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef struct packed {
		logic [KEY_W-1:0]          key;
		logic [MOVE_W-1:0]         move;
		logic [BOUND_W-1:0]        bound;
		logic [DEPTH_W-1:0]        depth;
		logic signed [SCORE_W-1:0] score;
	} entry_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} store_ctl_t;

endpackage

/* hw/rtl/dmht_mod_unit.sv */
// ----------------------------------------------------------------------------
// dmht_mod_unit
// Bit-serial restoring remainder of a 64-bit key by the slot count, one key
// bit per cycle; done pulses for one cycle when the remainder is ready.
// ----------------------------------------------------------------------------
module dmht_mod_unit
	import dmht_pkg::*;
#(
	parameter int DIV_W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-2:0] rem
);

	logic [KEY_W-1:0] key_q;
	logic [DIV_W-1:0] div_q;
	logic [DIV_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic [DIV_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, key_q[KEY_W-1]};
		diff     = trial - {1'b0, div_q};
		rem_next = (trial >= {1'b0, div_q}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(KEY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			key_q <= {key_q[KEY_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q[DIV_W-2:0];

endmodule

/* hw/rtl/dmht_store.sv */
// ----------------------------------------------------------------------------
// dmht_store
// Single-port-per-side synchronous entry memory holding key and payload of
// every slot; read data registered.
// ----------------------------------------------------------------------------
module dmht_store
	import dmht_pkg::*;
#(
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  store_ctl_t               ctl,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  entry_t                   wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output entry_t                   rd_data
);

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/direct_mapped_hash_table_core.sv */
// ----------------------------------------------------------------------------
// direct_mapped_hash_table_core
// Direct-mapped hash table: probe, store or clear by 64-bit key, slot chosen
// as key modulo the configured capacity, 0 read as 1, capped at TABLE_ENTRIES.
// ----------------------------------------------------------------------------
//  port group    direction  handshake                    carries
//  item          in         item_valid / item_ready      action, key, new entry
//  result        out        result_valid / result_ready  hit, found entry
//  cfg           in         cfg_wr_en                    table capacity
//
//  probe: the bit-serial modulo, one memory read, then one compare into the
//  output register; item_ready returns with the result word. store: written
//  when the modulo is done, then item_ready returns. clear: every slot is
//  swept to zero, then item_ready returns. after reset the memory is swept to
//  zero with item_ready low. one word in flight; a held result stalls the next
//  probe only at its compare step.
// ----------------------------------------------------------------------------
module direct_mapped_hash_table_core
	import dmht_pkg::*;
#(
	parameter int TABLE_ENTRIES = 65536
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      cfg_wr_en,
	input  logic [CAP_W-1:0]          cfg_wr_data,

	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic [1:0]                action,
	input  logic [KEY_W-1:0]          position_key,
	input  logic signed [SCORE_W-1:0] new_score,
	input  logic [DEPTH_W-1:0]        new_depth,
	input  logic [BOUND_W-1:0]        new_bound,
	input  logic [MOVE_W-1:0]         new_move,

	output logic                      result_valid,
	input  logic                      result_ready,
	output logic                      hit,
	output logic signed [SCORE_W-1:0] found_score,
	output logic [DEPTH_W-1:0]        found_depth,
	output logic [BOUND_W-1:0]        found_bound,
	output logic [MOVE_W-1:0]         found_move
);

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int ECAP_W = IDX_W + 1;
	localparam int CMP_W  = (CAP_W > ECAP_W) ? CAP_W : ECAP_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(TABLE_ENTRIES);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_RESP
	} state_t;

	state_t            state_q;
	logic [CAP_W-1:0]  cap_q;
	logic [IDX_W-1:0]  clr_idx_q;
	action_t           act_q;
	entry_t            entry_q;

	logic                      result_valid_q;
	logic                      hit_q;
	logic signed [SCORE_W-1:0] found_score_q;
	logic [DEPTH_W-1:0]        found_depth_q;
	logic [BOUND_W-1:0]        found_bound_q;
	logic [MOVE_W-1:0]         found_move_q;

	logic [CMP_W-1:0]  cap_ext;
	logic [CMP_W-1:0]  ecap_wide;
	logic [ECAP_W-1:0] ecap;
	logic              accept;
	logic              div_start;
	logic              div_done;
	logic [IDX_W-1:0]  slot;
	store_ctl_t        store_ctl;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;
	entry_t            rd_data;
	logic              key_match;
	logic              out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_comb begin
		cap_ext = CMP_W'(cap_q);
		if (cap_q == '0) begin
			ecap_wide = CMP_W'(1);
		end else if (cap_ext > ENTRIES_C) begin
			ecap_wide = ENTRIES_C;
		end else begin
			ecap_wide = cap_ext;
		end
		ecap = ecap_wide[ECAP_W-1:0];
	end

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign div_start  = accept && (action == ACT_PROBE || action == ACT_STORE);

	dmht_mod_unit #(
		.DIV_W (ECAP_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (position_key),
		.divisor  (ecap),
		.done     (div_done),
		.rem      (slot)
	);

	always_comb begin
		store_ctl.wr_en = (state_q == S_CLEAR)
			|| (state_q == S_DIV && div_done && act_q == ACT_STORE);
		store_ctl.rd_en = (state_q == S_DIV && div_done && act_q == ACT_PROBE);
		wr_addr = (state_q == S_CLEAR) ? clr_idx_q : slot;
		wr_data = (state_q == S_CLEAR) ? '0 : entry_q;
	end

	dmht_store #(
		.DEPTH (TABLE_ENTRIES)
	) u_store (
		.clk     (clk),
		.ctl     (store_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (slot),
		.rd_data (rd_data)
	);

	assign key_match = (rd_data.key == entry_q.key);
	assign out_free  = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_idx_q      <= '0;
			act_q          <= ACT_NONE;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RESP && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						act_q <= action_t'(action);
						case (action)
							ACT_PROBE, ACT_STORE: begin
								state_q <= S_DIV;
							end
							ACT_CLEAR: begin
								clr_idx_q <= '0;
								state_q   <= S_CLEAR;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= (act_q == ACT_PROBE) ? S_RESP : S_IDLE;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q.key   <= position_key;
			entry_q.score <= new_score;
			entry_q.depth <= new_depth;
			entry_q.bound <= new_bound;
			entry_q.move  <= new_move;
		end
		if (state_q == S_RESP && out_free) begin
			hit_q         <= key_match;
			found_score_q <= key_match ? rd_data.score : '0;
			found_depth_q <= key_match ? rd_data.depth : '0;
			found_bound_q <= key_match ? rd_data.bound : '0;
			found_move_q  <= key_match ? rd_data.move  : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign hit          = hit_q;
	assign found_score  = found_score_q;
	assign found_depth  = found_depth_q;
	assign found_bound  = found_bound_q;
	assign found_move   = found_move_q;

endmodule

/* tb/direct_mapped_hash_table_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_hash_table_checker
// Watches the item, result and capacity ports of the hash table core. It
// keeps its own copy of the slot array and the capacity, works out the
// answer to every accepted probe, and compares each accepted result word
// field by field with the oldest answer still due.
// ----------------------------------------------------------------------------
module direct_mapped_hash_table_checker
	import dmht_pkg::*;
#(
	parameter int TABLE_ENTRIES = 65536
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      cfg_wr_en,
	input  logic [CAP_W-1:0]          cfg_wr_data,

	input  logic                      item_valid,
	input  logic                      item_ready,
	input  logic [1:0]                action,
	input  logic [KEY_W-1:0]          position_key,
	input  logic signed [SCORE_W-1:0] new_score,
	input  logic [DEPTH_W-1:0]        new_depth,
	input  logic [BOUND_W-1:0]        new_bound,
	input  logic [MOVE_W-1:0]         new_move,

	input  logic                      result_valid,
	input  logic                      result_ready,
	input  logic                      hit,
	input  logic signed [SCORE_W-1:0] found_score,
	input  logic [DEPTH_W-1:0]        found_depth,
	input  logic [BOUND_W-1:0]        found_bound,
	input  logic [MOVE_W-1:0]         found_move,

	output int                        fail_count,
	output int                        pending
);

	typedef struct packed {
		logic                      hit;
		logic signed [SCORE_W-1:0] score;
		logic [DEPTH_W-1:0]        depth;
		logic [BOUND_W-1:0]        bound;
		logic [MOVE_W-1:0]         move;
	} lookup_t;

	entry_t           slots [TABLE_ENTRIES];
	logic [CAP_W-1:0] capacity;
	lookup_t          lookups_due [$];

	function automatic int unsigned slot_index(logic [KEY_W-1:0] key);
		logic [KEY_W-1:0] modulus;
		modulus = KEY_W'(capacity);
		if (modulus == '0)
			modulus = KEY_W'(1);
		if (modulus > KEY_W'(TABLE_ENTRIES))
			modulus = KEY_W'(TABLE_ENTRIES);
		return 32'(key % modulus);
	endfunction

	task automatic wipe_slots();
		for (int i = 0; i < TABLE_ENTRIES; i++)
			slots[i] = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		lookup_t     want;
		int unsigned idx;
		if (!arst_n) begin
			wipe_slots();
			capacity = CAP_RESET;
			lookups_due.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (lookups_due.size() == 0) begin
					$error("result word with no probe waiting");
					fail_count++;
				end else begin
					want = lookups_due.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0d, actual %0d", want.hit, hit);
						fail_count++;
					end
					if (found_score !== want.score) begin
						$error("found_score: expected %0d, actual %0d", want.score, found_score);
						fail_count++;
					end
					if (found_depth !== want.depth) begin
						$error("found_depth: expected %0d, actual %0d", want.depth, found_depth);
						fail_count++;
					end
					if (found_bound !== want.bound) begin
						$error("found_bound: expected %0d, actual %0d", want.bound, found_bound);
						fail_count++;
					end
					if (found_move !== want.move) begin
						$error("found_move: expected %0d, actual %0d", want.move, found_move);
						fail_count++;
					end
				end
			end
			if (cfg_wr_en)
				capacity = cfg_wr_data;
			if (item_valid && item_ready) begin
				idx = slot_index(position_key);
				case (action_t'(action))
					ACT_PROBE: begin
						want = '0;
						if (slots[idx].key == position_key) begin
							want.hit   = 1'b1;
							want.score = slots[idx].score;
							want.depth = slots[idx].depth;
							want.bound = slots[idx].bound;
							want.move  = slots[idx].move;
						end
						lookups_due.push_back(want);
					end
					ACT_STORE: begin
						slots[idx] = '{key: position_key, move: new_move, bound: new_bound,
							depth: new_depth, score: new_score};
					end
					ACT_CLEAR: begin
						wipe_slots();
					end
					default: begin
					end
				endcase
			end
			pending = lookups_due.size();
		end
	end

endmodule

/* tb/direct_mapped_hash_table_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_hash_table_core_tb
// Drives probes, stores, clears and ignored words into the hash table core
// under a series of capacities, with random idling on both channels and at
// least one long result hold-off. A checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module direct_mapped_hash_table_core_tb;
	import dmht_pkg::*;

	localparam int TABLE_ENTRIES = 65536;
	localparam int SETTLE        = 100;
	localparam int LONG_HOLD     = 2500;
	localparam int PHASE_WORDS   = 90;
	localparam int unsigned LIMIT = 2000000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_wr_en = 1'b0;
	logic [CAP_W-1:0]          cfg_wr_data = '0;
	logic                      item_valid = 1'b0;
	logic                      item_ready;
	logic [1:0]                action = ACT_PROBE;
	logic [KEY_W-1:0]          position_key = '0;
	logic signed [SCORE_W-1:0] new_score = '0;
	logic [DEPTH_W-1:0]        new_depth = '0;
	logic [BOUND_W-1:0]        new_bound = '0;
	logic [MOVE_W-1:0]         new_move = '0;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	logic                      hit;
	logic signed [SCORE_W-1:0] found_score;
	logic [DEPTH_W-1:0]        found_depth;
	logic [BOUND_W-1:0]        found_bound;
	logic [MOVE_W-1:0]         found_move;
	int                        fail_count;
	int                        pending;

	bit                        sender_idling = 1'b1;
	bit                        receiver_idling = 1'b1;
	bit                        clear_outstanding = 1'b0;
	int                        hold_epoch = 0;
	longint unsigned           cur_modulus = 65521;
	logic [KEY_W-1:0]          stored_keys [$];
	int unsigned               cycle_count = 0;

	direct_mapped_hash_table_core #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.item_valid(item_valid), .item_ready(item_ready), .action(action),
		.position_key(position_key), .new_score(new_score), .new_depth(new_depth),
		.new_bound(new_bound), .new_move(new_move),
		.result_valid(result_valid), .result_ready(result_ready), .hit(hit),
		.found_score(found_score), .found_depth(found_depth),
		.found_bound(found_bound), .found_move(found_move)
	);

	direct_mapped_hash_table_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin : watchdog
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("direct_mapped_hash_table_core_tb: FAIL");
		$finish;
	end

	// result side: random hold bursts, plus one long hold on request
	initial begin : receiver
		int seen_epoch;
		int gap;
		seen_epoch = 0;
		forever begin
			@(negedge clk);
			if (hold_epoch != seen_epoch) begin
				seen_epoch = hold_epoch;
				result_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (receiver_idling && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 9);
				result_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	task automatic send_word(action_t act, logic [KEY_W-1:0] key, logic [SCORE_W-1:0] score,
		logic [DEPTH_W-1:0] depth, logic [BOUND_W-1:0] bound, logic [MOVE_W-1:0] move);
		int gap;
		@(negedge clk);
		if (sender_idling && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action       <= act;
		position_key <= key;
		new_score    <= score;
		new_depth    <= depth;
		new_bound    <= bound;
		new_move     <= move;
		item_valid   <= 1'b1;
		do @(posedge clk); while (!item_ready);
		if (act == ACT_CLEAR)
			clear_outstanding = 1'b1;
		else if (act == ACT_PROBE)
			clear_outstanding = 1'b0;
		if (act == ACT_STORE) begin
			stored_keys.push_back(key);
			if (stored_keys.size() > 48)
				void'(stored_keys.pop_front());
		end
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (clear_outstanding ? TABLE_ENTRIES + SETTLE : SETTLE) @(negedge clk);
		clear_outstanding = 1'b0;
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		wait_quiet();
		cfg_wr_data <= cap;
		cfg_wr_en   <= 1'b1;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		cur_modulus = (cap == '0) ? 64'd1
			: (cap > CAP_W'(TABLE_ENTRIES)) ? 64'(TABLE_ENTRIES) : 64'(cap);
	endtask

	function automatic logic [KEY_W-1:0] random_key();
		if ($urandom_range(0, 3) == 0)
			return KEY_W'($urandom_range(0, 300));
		return {$urandom, $urandom};
	endfunction

	function automatic logic [KEY_W-1:0] choose_key();
		int unsigned c;
		logic [KEY_W-1:0] k;
		c = $urandom_range(0, 9);
		if (stored_keys.size() == 0 || c < 3)
			return random_key();
		k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
		if (c < 5)
			k = k + cur_modulus * 64'($urandom_range(1, 3));
		return k;
	endfunction

	initial begin : stimulus
		logic [CAP_W-1:0] phase_caps [10];
		int counted;
		int r;
		phase_caps = '{17'd65536, 17'd2, 17'd65537, 17'd7, 17'd1, 17'd251, 17'd65521,
			17'd4093, 17'd0, 17'd131071};
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// key zero against cleared slots, extremes of the payload, aliasing
		send_word(ACT_PROBE, '0, '0, '0, '0, '0);
		send_word(ACT_PROBE, 64'd1, '0, '0, '0, '0);
		send_word(ACT_STORE, '1, 16'h8000, 8'hff, 2'd3, 16'hffff);
		send_word(ACT_PROBE, '1, '0, '0, '0, '0);
		send_word(ACT_STORE, 64'h5555_5555_5555_5555, 16'h7fff, '0, '0, '0);
		send_word(ACT_PROBE, 64'h5555_5555_5555_5555 + 64'd65521, '0, '0, '0, '0);
		send_word(ACT_PROBE, 64'h5555_5555_5555_5555, '0, '0, '0, '0);
		send_word(ACT_STORE, 64'd65521, 16'h1234, 8'h5a, 2'd2, 16'ha5c3);
		send_word(ACT_PROBE, '0, '0, '0, '0, '0);
		send_word(ACT_PROBE, 64'd65521, '0, '0, '0, '0);
		// unused action code changes nothing
		send_word(ACT_NONE, '1, '1, '1, '1, '1);
		send_word(ACT_PROBE, '1, '0, '0, '0, '0);
		send_word(ACT_CLEAR, '1, '1, '1, '1, '1);
		send_word(ACT_PROBE, '1, '0, '0, '0, '0);
		send_word(ACT_PROBE, '0, '0, '0, '0, '0);
		// capacity zero acts as one slot
		write_capacity(17'd0);
		send_word(ACT_STORE, 64'hdead_beef_0bad_f00d, 16'h0001, 8'h01, 2'd1, 16'h0001);
		send_word(ACT_STORE, 64'hdead_beef_0bad_f00e, 16'hfffe, 8'hfe, 2'd2, 16'hfffe);
		send_word(ACT_PROBE, 64'hdead_beef_0bad_f00d, '0, '0, '0, '0);
		send_word(ACT_PROBE, 64'hdead_beef_0bad_f00e, '0, '0, '0, '0);
		// capacity above the table saturates
		write_capacity(17'h1ffff);
		send_word(ACT_STORE, 64'hf00d_0000_0001_ffff, 16'h4321, 8'h80, 2'd3, 16'h8001);
		send_word(ACT_PROBE, 64'hf00d_0000_0001_ffff, '0, '0, '0, '0);
		send_word(ACT_PROBE, 64'h0000_0000_0000_ffff, '0, '0, '0, '0);

		for (int p = 0; p < 10; p++) begin
			sender_idling   = (p != 5) && (p != 9);
			receiver_idling = (p != 5) && (p != 9);
			write_capacity(phase_caps[p]);
			stored_keys.delete();
			if (p == 3 || p == 6)
				send_word(ACT_CLEAR, random_key(), SCORE_W'($urandom), DEPTH_W'($urandom),
					BOUND_W'($urandom), MOVE_W'($urandom));
			counted = 0;
			while (counted < PHASE_WORDS) begin
				r = $urandom_range(0, 99);
				if (p == 4 && counted == 1)
					hold_epoch++;
				if (r < 3) begin
					send_word(ACT_NONE, random_key(), SCORE_W'($urandom), DEPTH_W'($urandom),
						BOUND_W'($urandom), MOVE_W'($urandom));
				end else begin
					if (r < 42)
						send_word(ACT_STORE, choose_key(), SCORE_W'($urandom),
							DEPTH_W'($urandom), BOUND_W'($urandom), MOVE_W'($urandom));
					else if (r < 46)
						send_word(ACT_PROBE, '0, SCORE_W'($urandom), DEPTH_W'($urandom),
							BOUND_W'($urandom), MOVE_W'($urandom));
					else
						send_word(ACT_PROBE, choose_key(), SCORE_W'($urandom),
							DEPTH_W'($urandom), BOUND_W'($urandom), MOVE_W'($urandom));
					counted++;
				end
			end
		end

		wait_quiet();
		if (fail_count == 0 && pending == 0)
			$display("direct_mapped_hash_table_core_tb: PASS");
		else
			$display("direct_mapped_hash_table_core_tb: FAIL");
		$finish;
	end

endmodule
